// File: rtl/core/i2cbs_pkg.sv
// Shared types and codes for the I2C master bit sequencer.
// Used by the step unit, the sequencer control and the top level.
package i2cbs_pkg;

  typedef enum logic [2:0] {
    ACT_START = 3'd0,
    ACT_STOP  = 3'd1,
    ACT_WRITE = 3'd2,
    ACT_READ  = 3'd3,
    ACT_SACK  = 3'd4,
    ACT_RACK  = 3'd5
  } action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  localparam int unsigned PHASE_W = 2;
  localparam int unsigned BIT_W   = 4;
  localparam logic [BIT_W-1:0] LAST_DATA_BIT = BIT_W'(7);
  localparam logic [BIT_W-1:0] ACK_BIT_SLOT  = BIT_W'(8);

  // Position of the sequencer inside the current command.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BIT_W-1:0]   bit_idx;
  } seq_pos_t;

  // One line change as worked out by the step unit.
  typedef struct packed {
    logic     scl;
    logic     sda;
    logic     last;
    logic     shift_tx;
    logic     sample_rx;
    seq_pos_t next_pos;
  } step_t;

endpackage

// File: rtl/core/i2cbs_step.sv
// Step unit: computes the next line change from the command and position.
// Depends on i2cbs_pkg.
module i2cbs_step
  import i2cbs_pkg::*;
(
  input  action_t  action,
  input  seq_pos_t pos,
  input  logic     clock_line,
  input  logic     data_line,
  input  logic     shift_msb,
  input  logic     ack_bit,
  output step_t    step
);

  always_comb begin
    step.scl                = clock_line;
    step.sda                = data_line;
    step.last               = 1'b0;
    step.shift_tx           = 1'b0;
    step.sample_rx          = 1'b0;
    step.next_pos.phase     = pos.phase + PHASE_W'(1);
    step.next_pos.bit_idx   = pos.bit_idx;
    case (action)
      ACT_START: begin
        case (pos.phase)
          2'd0:    step.sda = 1'b1;
          2'd1:    step.scl = 1'b1;
          2'd2:    step.sda = 1'b0;
          default: begin
            step.scl  = 1'b0;
            step.last = 1'b1;
          end
        endcase
      end
      ACT_STOP: begin
        case (pos.phase)
          2'd0:    step.sda = 1'b0;
          2'd1:    step.scl = 1'b1;
          default: begin
            step.sda  = 1'b1;
            step.last = 1'b1;
          end
        endcase
      end
      ACT_WRITE: begin
        case (pos.phase)
          2'd0:    step.sda = shift_msb;
          2'd1:    step.scl = 1'b1;
          default: begin
            // After the last data bit the acknowledge clock pulse runs without a data phase.
            step.scl              = 1'b0;
            step.last             = (pos.bit_idx == ACK_BIT_SLOT);
            step.shift_tx         = (pos.bit_idx != ACK_BIT_SLOT);
            step.next_pos.bit_idx = pos.bit_idx + BIT_W'(1);
            step.next_pos.phase   = (pos.bit_idx == LAST_DATA_BIT) ? PHASE_W'(1)
                                                                  : PHASE_W'(0);
          end
        endcase
      end
      ACT_READ: begin
        case (pos.phase)
          2'd0:    step.sda = 1'b1;
          2'd1: begin
            step.scl       = 1'b1;
            step.sample_rx = 1'b1;
          end
          default: begin
            step.scl              = 1'b0;
            step.last             = (pos.bit_idx == LAST_DATA_BIT);
            step.next_pos.bit_idx = pos.bit_idx + BIT_W'(1);
            step.next_pos.phase   = PHASE_W'(1);
          end
        endcase
      end
      ACT_SACK, ACT_RACK: begin
        case (pos.phase)
          2'd0:    step.sda = (action == ACT_SACK) ? ack_bit : 1'b1;
          2'd1:    step.scl = 1'b1;
          default: begin
            step.scl  = 1'b0;
            step.last = 1'b1;
          end
        endcase
      end
      default: step.last = 1'b1;
    endcase
  end

endmodule

// File: rtl/core/i2cbs_ctrl.sv
// Sequencer control: idle/run state machine and position counters.
// Depends on i2cbs_pkg.
module i2cbs_ctrl
  import i2cbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     out_free,
  input  step_t    step,
  output logic     ready,
  output logic     advance,
  output seq_pos_t pos
);

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        state_next = ST_RUN;
      end
      ST_RUN: if (out_free && step.last) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready   = 1'b0;
    advance = 1'b0;
    case (state)
      ST_IDLE: ready   = 1'b1;
      ST_RUN:  advance = out_free;
      default: ready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        pos <= '0;
      end else if (advance) begin
        pos <= step.next_pos;
      end
    end
  end

endmodule

// File: rtl/core/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: command capture, shared shift
// register, bus line state and the result output register.
// Depends on i2cbs_pkg, i2cbs_step and i2cbs_ctrl.
//
// Usage: a command beat on the s_axis channel (action in tuser) starts a run
// of line changes, each delivered as one beat on m_axis carrying the SCL and
// SDA levels after that change; tlast marks the final change of the run.
// Start gives 4 beats, stop 3, send and receive ack 3, read 17, write 26.
// The first result is loaded into the output register once the control has
// entered its run state, and further results follow one per cycle while
// m_axis_tready is high. s_axis_tready is low from acceptance until the last
// result has been loaded into the output register. Action codes 6 and 7 are
// taken and give no results. When the receiver stalls, the output register
// holds its beat and the sequence pauses with it.
// Reset returns both bus lines to the released (high) level, empties the
// output register and makes the block ready for a command.
module i2c_master_bit_sequencer_unit
  import i2cbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: byte_out[7:0], ack_to_send[8], bus_byte[16:9], bus_ack[17], zero pad
  input  logic [23:0] s_axis_tdata,
  // tuser: action[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: scl_level[0], sda_level[1], read_value[9:2], ack_seen[10], zero pad
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  action_t  in_action;
  logic     accept;
  logic     start;
  logic     out_free;
  logic     ready;
  logic     advance;
  seq_pos_t pos;
  step_t    step;

  action_t     cur_action;
  logic [7:0]  shreg;
  logic [7:0]  rx;
  logic        ack_bit;
  logic        bus_ack;
  logic        clock_line;
  logic        data_line;
  logic [7:0]  read_value;
  logic        ack_seen;

  assign in_action     = action_t'(s_axis_tuser);
  assign s_axis_tready = ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = accept && (s_axis_tuser <= ACT_RACK);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  i2cbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .step     (step),
    .ready    (ready),
    .advance  (advance),
    .pos      (pos)
  );

  i2cbs_step u_step (
    .action     (cur_action),
    .pos        (pos),
    .clock_line (clock_line),
    .data_line  (data_line),
    .shift_msb  (shreg[7]),
    .ack_bit    (ack_bit),
    .step       (step)
  );

  // The shift register holds the byte to send on a write and the slave's
  // levels on a read; the receive register picks up its top bit at each
  // read sample point.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_action <= in_action;
      shreg      <= (in_action == ACT_READ) ? s_axis_tdata[16:9] : s_axis_tdata[7:0];
      ack_bit    <= s_axis_tdata[8];
      bus_ack    <= s_axis_tdata[17];
      rx         <= '0;
    end else if (advance) begin
      if (step.shift_tx || step.sample_rx) begin
        shreg <= {shreg[6:0], 1'b0};
      end
      if (step.sample_rx) begin
        rx <= {rx[6:0], shreg[7]};
      end
    end
  end

  always_comb begin
    read_value = '0;
    ack_seen   = 1'b0;
    if (step.last && (cur_action == ACT_READ)) begin
      read_value = rx;
    end
    if (step.last && (cur_action == ACT_RACK)) begin
      ack_seen = bus_ack;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_line    <= 1'b1;
      data_line     <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        clock_line    <= step.scl;
        data_line     <= step.sda;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'b0, ack_seen, read_value, step.sda, step.scl};
      m_axis_tlast <= step.last;
    end
  end

`ifndef ASSERT_OFF
  // A pending result always shows the levels the bus lines now hold.
  a_lines_match : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == clock_line) && (m_axis_tdata[1] == data_line))
    else $error("output beat does not match bus line state");

  // Received data and ack only appear on the final beat of a run.
  a_data_on_last : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[10:2] == '0))
    else $error("read data or ack seen on a beat that is not the last");

  // A start condition leaves both lines driven low.
  a_start_ends_low : assert property (@(posedge clk) disable iff (rst)
    (advance && step.last && (cur_action == ACT_START))
      |-> (!step.scl && !step.sda))
    else $error("start run did not end with both lines low");

  // A new command is only taken once the previous run has finished.
  a_no_overlap : assert property (@(posedge clk) disable iff (rst)
    advance |-> !s_axis_tready)
    else $error("command port ready while a run is in progress");
`endif

endmodule

// File: dv/i2c_master_bit_sequencer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master bit sequencer top level.
// Drives command beats, predicts every line-change beat and checks each one.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer_unit.
module i2c_master_bit_sequencer_unit_test;
  import i2cbs_pkg::*;

  // Action codes that the block takes without producing any beats.
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 245;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_out;
    logic       ack_to_send;
    logic [7:0] bus_byte;
    logic       bus_ack;
  } bus_cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       last;
    logic [7:0] read_value;
    logic       ack_seen;
  } line_change_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  bus_cmd_t     pending_cmds[$];
  line_change_t line_changes_due[$];

  // Bus line levels as the predictor tracks them.
  logic        bus_scl;
  logic        bus_sda;

  int unsigned total_cmds;
  int unsigned accepted_cmds = 0;
  int unsigned beats_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  bus_cmd_t    drive_cmd;

  i2c_master_bit_sequencer_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned seen,
                                 input int unsigned want);
    $display("beat %0d: %s is %0h, expected %0h", beats_seen, what, seen, want);
    mismatches++;
  endtask

  task automatic add_change(input logic scl, input logic sda, input logic last,
                            input logic [7:0] read_value, input logic ack_seen);
    line_change_t lc;
    bus_scl = scl;
    bus_sda = sda;
    lc.scl = scl;
    lc.sda = sda;
    lc.last = last;
    lc.read_value = read_value;
    lc.ack_seen = ack_seen;
    line_changes_due.push_back(lc);
  endtask

  // Expands one command into the line changes it drives on the bus.
  task automatic sequence_command(input bus_cmd_t cmd);
    int i;
    case (cmd.action)
      ACT_START: begin
        add_change(bus_scl, 1'b1, 1'b0, 8'd0, 1'b0);
        add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
        add_change(bus_scl, 1'b0, 1'b0, 8'd0, 1'b0);
        add_change(1'b0, bus_sda, 1'b1, 8'd0, 1'b0);
      end
      ACT_STOP: begin
        add_change(bus_scl, 1'b0, 1'b0, 8'd0, 1'b0);
        add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
        add_change(bus_scl, 1'b1, 1'b1, 8'd0, 1'b0);
      end
      ACT_WRITE: begin
        for (i = 7; i >= 0; i--) begin
          add_change(bus_scl, cmd.byte_out[i], 1'b0, 8'd0, 1'b0);
          add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
          add_change(1'b0, bus_sda, 1'b0, 8'd0, 1'b0);
        end
        // The acknowledge clock pulse is sent but its acknowledge is not sampled.
        add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
        add_change(1'b0, bus_sda, 1'b1, 8'd0, 1'b0);
      end
      ACT_READ: begin
        add_change(bus_scl, 1'b1, 1'b0, 8'd0, 1'b0);
        for (i = 7; i >= 0; i--) begin
          add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
          add_change(1'b0, bus_sda, i == 0, (i == 0) ? cmd.bus_byte : 8'd0, 1'b0);
        end
      end
      ACT_SACK: begin
        add_change(bus_scl, cmd.ack_to_send, 1'b0, 8'd0, 1'b0);
        add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
        add_change(1'b0, bus_sda, 1'b1, 8'd0, 1'b0);
      end
      ACT_RACK: begin
        add_change(bus_scl, 1'b1, 1'b0, 8'd0, 1'b0);
        add_change(1'b1, bus_sda, 1'b0, 8'd0, 1'b0);
        add_change(1'b0, bus_sda, 1'b1, 8'd0, cmd.bus_ack);
      end
      default: ;
    endcase
  endtask

  task automatic check_line_change();
    line_change_t want;
    if (line_changes_due.size() == 0) begin
      report_mismatch("unexpected beat", 32'(m_axis_tdata), 32'd0);
    end else begin
      want = line_changes_due.pop_front();
      if (m_axis_tdata[0] !== want.scl)
        report_mismatch("scl_level", 32'(m_axis_tdata[0]), 32'(want.scl));
      if (m_axis_tdata[1] !== want.sda)
        report_mismatch("sda_level", 32'(m_axis_tdata[1]), 32'(want.sda));
      if (m_axis_tdata[9:2] !== want.read_value)
        report_mismatch("read_value", 32'(m_axis_tdata[9:2]), 32'(want.read_value));
      if (m_axis_tdata[10] !== want.ack_seen)
        report_mismatch("ack_seen", 32'(m_axis_tdata[10]), 32'(want.ack_seen));
      if (m_axis_tdata[15:11] !== 5'd0)
        report_mismatch("tdata padding", 32'(m_axis_tdata[15:11]), 32'd0);
      if (m_axis_tlast !== want.last)
        report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
    end
    beats_seen++;
  endtask

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Command driver: holds each beat until taken, then idles for a drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_wait = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_wait != 0) begin
        s_axis_tvalid <= 1'b0;
        send_wait = send_wait - 1;
      end else if (pending_cmds.size() != 0) begin
        drive_cmd = pending_cmds.pop_front();
        s_axis_tdata <= {6'd0, drive_cmd.bus_ack, drive_cmd.bus_byte,
                         drive_cmd.ack_to_send, drive_cmd.byte_out};
        s_axis_tuser <= drive_cmd.action;
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 23) == 0) send_calm = !send_calm;
        send_wait = draw_wait(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: after each beat, ready drops for a drawn stall, which may be zero.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_wait = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 23) == 0) recv_calm = !recv_calm;
      recv_wait = draw_wait(recv_calm);
      m_axis_tready <= (recv_wait == 0);
    end else if (!m_axis_tready) begin
      if (recv_wait <= 1) begin
        m_axis_tready <= 1'b1;
        recv_wait = 0;
      end else begin
        recv_wait = recv_wait - 1;
      end
    end
  end

  // Monitor: predicts on every command beat and checks every result beat.
  always @(posedge clk) begin
    bus_cmd_t taken;
    if (rst) begin
      bus_scl = 1'b1;
      bus_sda = 1'b1;
      idle_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken.action = s_axis_tuser;
        taken.byte_out = s_axis_tdata[7:0];
        taken.ack_to_send = s_axis_tdata[8];
        taken.bus_byte = s_axis_tdata[16:9];
        taken.bus_ack = s_axis_tdata[17];
        sequence_command(taken);
        accepted_cmds++;
      end
      if (m_axis_tvalid && m_axis_tready) check_line_change();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic bus_cmd_t random_cmd(input logic [2:0] action);
    bus_cmd_t c;
    c.action = action;
    c.byte_out = 8'($urandom_range(0, 255));
    c.ack_to_send = 1'($urandom_range(0, 1));
    c.bus_byte = 8'($urandom_range(0, 255));
    c.bus_ack = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic bus_cmd_t fixed_cmd(input logic [2:0] action, input logic [7:0] byte_out,
                                         input logic ack_to_send, input logic [7:0] bus_byte,
                                         input logic bus_ack);
    bus_cmd_t c;
    c.action = action;
    c.byte_out = byte_out;
    c.ack_to_send = ack_to_send;
    c.bus_byte = bus_byte;
    c.bus_ack = bus_ack;
    return c;
  endfunction

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned nbytes;
    logic [7:0]  addr;
    bit          is_read;

    // Directed part: field extremes, every action, spare codes, ignored fields.
    pending_cmds.push_back(fixed_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_WRITE, 8'h00, 1'b0, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_RACK, 8'h00, 1'b0, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_WRITE, 8'hFF, 1'b1, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_RACK, 8'hFF, 1'b1, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_READ, 8'hFF, 1'b1, 8'h00, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_SACK, 8'hFF, 1'b0, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_READ, 8'h00, 1'b0, 8'hFF, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_SACK, 8'h00, 1'b1, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_READ, 8'h00, 1'b0, 8'h5A, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_SPARE_LO, 8'hFF, 1'b1, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_SPARE_HI, 8'hFF, 1'b1, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_STOP, 8'hFF, 1'b1, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_START, 8'hFF, 1'b1, 8'hFF, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_WRITE, 8'h80, 1'b1, 8'h01, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_WRITE, 8'h01, 1'b0, 8'h80, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_READ, 8'h5A, 1'b1, 8'h01, 1'b1));
    pending_cmds.push_back(fixed_cmd(ACT_READ, 8'hA5, 1'b0, 8'h80, 1'b0));
    pending_cmds.push_back(fixed_cmd(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0));

    // Random part: mostly well-formed transfers with random content, some noise.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_cmds.push_back(random_cmd(3'($urandom_range(0, 7))));
        if (pending_cmds[$].action < ACT_SPARE_LO) n++;
      end else begin
        pending_cmds.push_back(random_cmd(ACT_START));
        addr = 8'($urandom_range(0, 255));
        is_read = addr[0];
        pending_cmds.push_back(fixed_cmd(ACT_WRITE, addr, 1'($urandom_range(0, 1)),
                                         8'($urandom_range(0, 255)),
                                         1'($urandom_range(0, 1))));
        pending_cmds.push_back(random_cmd(ACT_RACK));
        n += 3;
        nbytes = $urandom_range(1, 4);
        for (k = 0; k < nbytes; k++) begin
          if (is_read) begin
            pending_cmds.push_back(random_cmd(ACT_READ));
            // The master acknowledges every byte but the last one.
            pending_cmds.push_back(fixed_cmd(ACT_SACK, 8'($urandom_range(0, 255)),
                                             k == nbytes - 1, 8'($urandom_range(0, 255)),
                                             1'($urandom_range(0, 1))));
          end else begin
            pending_cmds.push_back(random_cmd(ACT_WRITE));
            pending_cmds.push_back(random_cmd(ACT_RACK));
          end
          n += 2;
        end
        // Some transfers end in a repeated start instead of a stop.
        if ($urandom_range(0, 3) != 0) begin
          pending_cmds.push_back(random_cmd(ACT_STOP));
          n++;
        end
      end
    end
    pending_cmds.push_back(random_cmd(ACT_STOP));
    total_cmds = pending_cmds.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cmds != total_cmds || line_changes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (line_changes_due.size() != 0)
      report_mismatch("beats still due", line_changes_due.size(), 32'd0);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
